FILE: design/osr_pkg.sv
// shared types, op codes and saturating helpers for the ode shooting residual block
// no dependencies
package osr_pkg;

  localparam int unsigned StepsW = 13;

  typedef struct packed {
    logic signed [63:0] wavenumber;
    logic signed [63:0] omega_real;
    logic signed [63:0] omega_imag;
  } in_t;

  typedef struct packed {
    logic [62:0] residual;
    logic        saturated;
  } out_t;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t RegReynolds = 1'b0;
  localparam cfg_idx_t RegSteps    = 1'b1;

  typedef enum logic [4:0] {
    OP_KZ2, OP_WIR, OP_BI, OP_WRR, OP_AHR, OP_AHI, OP_G1R, OP_G1I,
    OP_KEEP1, OP_KEEP2, OP_CPL1, OP_CPL2,
    OP_GR0, OP_GR1, OP_GR2, OP_GI0, OP_GI1, OP_GI2,
    OP_SQR, OP_SQI, OP_ROOT
  } op_e;

  typedef enum logic [1:0] {DIV_ONE, DIV_FX, DIV_GEN} div_e;

  typedef struct packed {
    logic load;
    logic go;
    op_e  op;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic loop_end;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic signed [63:0] val;
    logic               ovf;
  } sres_t;

  localparam logic [63:0] SMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMin = 64'h8000_0000_0000_0000;

  function automatic sres_t sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    sres_t r;
    s = {a[63], a} + {b[63], b};
    r.ovf = s[64] != s[63];
    r.val = r.ovf ? (s[64] ? SMin : SMax) : s[63:0];
    return r;
  endfunction

  function automatic sres_t sat_sub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    sres_t r;
    s = {a[63], a} - {b[63], b};
    r.ovf = s[64] != s[63];
    r.val = r.ovf ? (s[64] ? SMin : SMax) : s[63:0];
    return r;
  endfunction

  function automatic sres_t sat_neg(logic signed [63:0] a);
    sres_t r;
    r.ovf = a == SMin;
    r.val = r.ovf ? SMax : -a;
    return r;
  endfunction

endpackage

FILE: design/ode_shooting_residual_top.sv
// top level of the ode shooting residual block: config registers, controller, datapath
// instantiates osr_ctrl and osr_dp; uses osr_pkg
//
//  channel  | dir | handshake                | payload
//  ---------+-----+--------------------------+-----------------------------------------
//  in       | in  | in_valid_i / in_stall_o  | in_data_i  (wavenumber, omega re/im)
//  out      | out | out_valid_o / out_stall_i| out_data_o (residual, saturated)
//  cfg      | in  | cfg_we_i                 | cfg_idx_i, cfg_data_i (reynolds, steps)
//
//  the single shared bit-serial divider sets the time from one accept to the next
//  accept, which grows with the number of recurrence steps
//  one item in flight; the next is taken once its result sits in the output register
//  asynchronous active-low reset, no memories, no clearing pass
//  a stalled result holds the output register while a new item may already enter
module ode_shooting_residual_top #(
  parameter int unsigned MAX_STEPS = 4096,
  parameter int unsigned FRAC_BITS = 44
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  osr_pkg::in_t          in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output osr_pkg::out_t         out_data_o,
  input  logic                  cfg_we_i,
  input  osr_pkg::cfg_idx_t     cfg_idx_i,
  input  logic [62:0]           cfg_data_i
);

  // config registers, to be written only while idle; the block itself does not enforce it
  logic [62:0]                    reynolds_q;
  logic [osr_pkg::StepsW-1:0]     steps_q;

  osr_pkg::cmd_t  cmd;
  osr_pkg::stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reynolds_q <= 63'd1 << FRAC_BITS;
      steps_q    <= 13'd2048;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        osr_pkg::RegReynolds: reynolds_q <= cfg_data_i;
        osr_pkg::RegSteps:    steps_q    <= cfg_data_i[osr_pkg::StepsW-1:0];
        default:              steps_q    <= steps_q;
      endcase
    end
  end

  // sequencer for the op list and the k loop
  osr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // arithmetic, state registers and output register
  osr_dp #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .reynolds_i  (reynolds_q),
    .steps_i     (steps_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: design/osr_mdu.sv
// shared multiply, round and divide unit: round(x*y/d), round(x*y/2^FRAC_BITS) or x*y, with saturation
// four 32x32 partial products accumulated, bit-serial restoring divide; uses osr_pkg
module osr_mdu #(
  parameter int unsigned FRAC_BITS = 44
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] x_i,
  input  logic signed [63:0] y_i,
  input  osr_pkg::div_e      mode_i,
  input  logic [63:0]        d_i,
  output logic               done_o,
  output logic signed [63:0] q_o,
  output logic               sat_o,
  output logic [127:0]       prod_o
);

  typedef enum logic [2:0] {M_IDLE, M_MUL, M_ROUND, M_DIV, M_FIN} mstate_e;

  mstate_e            state_q;
  logic [6:0]         cnt_q;
  logic [63:0]        a_q, b_q, d_q;
  logic               neg_q;
  osr_pkg::div_e      mode_q;
  logic [127:0]       acc_q;
  logic [62:0]        rem_q;
  logic signed [63:0] q_q;
  logic               sat_q, done_q;

  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] pp_sh, rnd, sum_rnd;
  logic [63:0]  trial, limit, qmag;
  logic         fits, over;

  always_comb begin
    a_half = cnt_q[0] ? a_q[63:32] : a_q[31:0];
    b_half = cnt_q[1] ? b_q[63:32] : b_q[31:0];
    pp     = a_half * b_half;
    case (cnt_q[1:0])
      2'b00:   pp_sh = {64'd0, pp};
      2'b11:   pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    case (mode_q)
      osr_pkg::DIV_FX:  rnd = 128'd1 << (FRAC_BITS - 1);
      osr_pkg::DIV_GEN: rnd = {65'd0, d_q[63:1]};
      default:          rnd = 128'd0;
    endcase
    sum_rnd = acc_q + rnd;
    trial   = {rem_q, acc_q[127]};
    fits    = trial >= d_q;
    limit   = neg_q ? osr_pkg::SMin : osr_pkg::SMax;
    over    = (|acc_q[127:64]) || (acc_q[63:0] > limit);
    qmag    = over ? limit : acc_q[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            a_q     <= x_i[63] ? (~x_i + 64'd1) : x_i;
            b_q     <= y_i[63] ? (~y_i + 64'd1) : y_i;
            neg_q   <= x_i[63] ^ y_i[63];
            mode_q  <= mode_i;
            d_q     <= d_i;
            acc_q   <= 128'd0;
            cnt_q   <= 7'd0;
            state_q <= M_MUL;
          end
        end
        M_MUL: begin
          acc_q <= acc_q + pp_sh;
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q[1:0] == 2'b11) state_q <= M_ROUND;
        end
        M_ROUND: begin
          case (mode_q)
            osr_pkg::DIV_FX: begin
              acc_q   <= sum_rnd >> FRAC_BITS;
              state_q <= M_FIN;
            end
            osr_pkg::DIV_GEN: begin
              acc_q   <= sum_rnd;
              rem_q   <= 63'd0;
              cnt_q   <= 7'd0;
              state_q <= M_DIV;
            end
            default: state_q <= M_FIN;
          endcase
        end
        M_DIV: begin
          rem_q <= fits ? 63'(trial - d_q) : trial[62:0];
          acc_q <= {acc_q[126:0], fits};
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd127) state_q <= M_FIN;
        end
        M_FIN: begin
          q_q     <= neg_q ? (64'd0 - qmag) : qmag;
          sat_q   <= over;
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;
  assign sat_o  = sat_q;
  assign prod_o = acc_q;

endmodule

FILE: design/osr_sqrt.sv
// bit-pair restoring square root of a 128-bit value, one result bit per cycle
// no dependencies
module osr_sqrt (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] rad_i,
  output logic         done_o,
  output logic [63:0]  root_o
);

  logic         busy_q, done_q;
  logic [5:0]   cnt_q;
  logic [127:0] rad_q;
  logic [66:0]  rem_q;
  logic [63:0]  root_q;

  logic [66:0] rem_sh, trial;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q[64:0], rad_q[127:126]};
    trial  = {1'b0, root_q, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        rad_q  <= rad_i;
        rem_q  <= 67'd0;
        root_q <= 64'd0;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        rem_q  <= ge ? (rem_sh - trial) : rem_sh;
        root_q <= {root_q[62:0], ge};
        rad_q  <= {rad_q[125:0], 2'b00};
        cnt_q  <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: design/osr_dp.sv
// datapath: operand selection, coefficient and recurrence registers, result register
// instantiates osr_mdu and osr_sqrt; uses osr_pkg
module osr_dp #(
  parameter int unsigned FRAC_BITS = 44,
  parameter int unsigned MAX_STEPS = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  osr_pkg::cmd_t                  cmd_i,
  output osr_pkg::stat_t                 stat_o,
  input  osr_pkg::in_t                   in_data_i,
  input  logic [62:0]                    reynolds_i,
  input  logic [osr_pkg::StepsW-1:0]     steps_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output osr_pkg::out_t                  out_data_o
);

  localparam int unsigned StepCap = (MAX_STEPS > 8191) ? 8191 : MAX_STEPS;
  localparam logic [osr_pkg::StepsW-1:0] StepMax = osr_pkg::StepsW'(StepCap);
  localparam logic [63:0] FxOne = 64'd1 << FRAC_BITS;

  logic signed [63:0] kz_q, wr_q, wi_q;
  logic [12:0]        n_q, k_q;
  logic [25:0]        nn_q;
  logic signed [63:0] ar_q, ai_q, bi_q, ahr_q, ahi_q;
  logic signed [63:0] lr_q, li_q, br_q, bim_q, keep_q, cpl_q, t_q, gr_q;
  logic [127:0]       sq_q;
  logic [62:0]        res_q;
  logic               sat_q, done_q, out_valid_q;
  osr_pkg::op_e       op_q;
  osr_pkg::out_t      out_q;

  logic [12:0]        n_clamp;
  logic signed [63:0] x, y, r, k64;
  logic [63:0]        d;
  osr_pkg::div_e      mode;
  osr_pkg::sres_t     s1, s2;
  logic signed [63:0] wb_val;
  logic               wb_ovf;
  logic               mdu_done, mdu_sat, sqrt_done;
  logic [127:0]       mdu_prod;
  logic [63:0]        root;

  always_comb begin
    if (steps_i < 13'd2)         n_clamp = 13'd2;
    else if (steps_i > StepMax)  n_clamp = StepMax;
    else                         n_clamp = steps_i;
  end

  // operand selection for the op being issued
  always_comb begin
    k64  = 64'(k_q);
    x    = kz_q;
    y    = 64'sd1;
    mode = osr_pkg::DIV_FX;
    d    = 64'd1;
    case (cmd_i.op)
      osr_pkg::OP_KZ2:   y = kz_q;
      osr_pkg::OP_WIR:   begin x = wi_q; y = 64'(reynolds_i); end
      osr_pkg::OP_BI:    y = 64'(reynolds_i);
      osr_pkg::OP_WRR:   begin x = wr_q; y = 64'(reynolds_i); end
      osr_pkg::OP_AHR:   begin x = ar_q; mode = osr_pkg::DIV_GEN; d = 64'(n_q); end
      osr_pkg::OP_AHI:   begin x = ai_q; mode = osr_pkg::DIV_GEN; d = 64'(n_q); end
      osr_pkg::OP_G1R:   begin x = ar_q; mode = osr_pkg::DIV_GEN; d = 64'(n_q) << 3; end
      osr_pkg::OP_G1I:   begin x = ai_q; mode = osr_pkg::DIV_GEN; d = 64'(n_q) << 3; end
      osr_pkg::OP_KEEP1: begin x = FxOne; y = k64 << 3; mode = osr_pkg::DIV_ONE; end
      osr_pkg::OP_KEEP2: begin
        x = t_q; mode = osr_pkg::DIV_GEN; d = (k64 << 2) + 64'd4;
      end
      osr_pkg::OP_CPL1:  begin x = bi_q; y = k64; mode = osr_pkg::DIV_GEN; d = 64'(nn_q); end
      osr_pkg::OP_CPL2:  begin
        x = t_q; mode = osr_pkg::DIV_GEN; d = (k64 << 2) + 64'd4;
      end
      osr_pkg::OP_GR0:   begin
        x = br_q; y = 64'sd1 - k64; mode = osr_pkg::DIV_GEN; d = k64 + 64'd1;
      end
      osr_pkg::OP_GR1:   begin x = lr_q; y = keep_q; end
      osr_pkg::OP_GR2:   begin x = li_q; y = cpl_q; end
      osr_pkg::OP_GI0:   begin
        x = bim_q; y = 64'sd1 - k64; mode = osr_pkg::DIV_GEN; d = k64 + 64'd1;
      end
      osr_pkg::OP_GI1:   begin x = li_q; y = keep_q; end
      osr_pkg::OP_GI2:   begin x = cpl_q; y = lr_q; end
      osr_pkg::OP_SQR:   begin x = lr_q; y = lr_q; mode = osr_pkg::DIV_ONE; end
      osr_pkg::OP_SQI:   begin x = li_q; y = li_q; mode = osr_pkg::DIV_ONE; end
      default:           x = kz_q;
    endcase
  end

  osr_mdu #(.FRAC_BITS(FRAC_BITS)) u_mdu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.go && (cmd_i.op != osr_pkg::OP_ROOT)),
    .x_i     (x),
    .y_i     (y),
    .mode_i  (mode),
    .d_i     (d),
    .done_o  (mdu_done),
    .q_o     (r),
    .sat_o   (mdu_sat),
    .prod_o  (mdu_prod)
  );

  osr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.go && (cmd_i.op == osr_pkg::OP_ROOT)),
    .rad_i   (sq_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // post-op on the unit result
  always_comb begin
    s1     = osr_pkg::sat_neg(t_q);
    s2     = '0;
    wb_val = r;
    wb_ovf = 1'b0;
    case (op_q)
      osr_pkg::OP_WIR:   begin
        s2 = osr_pkg::sat_sub(s1.val, r); wb_ovf = s1.ovf | s2.ovf; wb_val = s2.val;
      end
      osr_pkg::OP_WRR:   s2 = osr_pkg::sat_sub(r, bi_q);
      osr_pkg::OP_G1R:   s2 = osr_pkg::sat_sub(FxOne, r);
      osr_pkg::OP_G1I:   s2 = osr_pkg::sat_neg(r);
      osr_pkg::OP_KEEP1: s2 = osr_pkg::sat_sub(r, ahr_q);
      osr_pkg::OP_CPL1:  s2 = osr_pkg::sat_add(r, ahi_q);
      osr_pkg::OP_GR1,
      osr_pkg::OP_GR2:   s2 = osr_pkg::sat_add(gr_q, r);
      osr_pkg::OP_GI1:   s2 = osr_pkg::sat_add(t_q, r);
      osr_pkg::OP_GI2:   s2 = osr_pkg::sat_sub(t_q, r);
      default:           s2 = '0;
    endcase
    if (op_q inside {osr_pkg::OP_WRR, osr_pkg::OP_G1R, osr_pkg::OP_G1I, osr_pkg::OP_KEEP1,
                     osr_pkg::OP_CPL1, osr_pkg::OP_GR1, osr_pkg::OP_GR2, osr_pkg::OP_GI1,
                     osr_pkg::OP_GI2}) begin
      wb_val = s2.val;
      wb_ovf = s2.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      sat_q       <= 1'b0;
      k_q         <= 13'd0;
    end else begin
      done_q <= mdu_done | sqrt_done;
      if (cmd_i.publish)   out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i.publish) begin
        out_q.residual  <= res_q;
        out_q.saturated <= sat_q;
      end
      if (cmd_i.load) begin
        kz_q  <= in_data_i.wavenumber;
        wr_q  <= in_data_i.omega_real;
        wi_q  <= in_data_i.omega_imag;
        n_q   <= n_clamp;
        nn_q  <= 26'(n_clamp) * 26'(n_clamp);
        k_q   <= 13'd1;
        sat_q <= 1'b0;
      end
      if (cmd_i.go) op_q <= cmd_i.op;
      if (mdu_done) begin
        if (op_q != osr_pkg::OP_SQR && op_q != osr_pkg::OP_SQI)
          sat_q <= sat_q | mdu_sat | wb_ovf;
        case (op_q)
          osr_pkg::OP_KZ2:   t_q   <= wb_val;
          osr_pkg::OP_WIR:   ar_q  <= wb_val;
          osr_pkg::OP_BI:    bi_q  <= wb_val;
          osr_pkg::OP_WRR:   ai_q  <= wb_val;
          osr_pkg::OP_AHR:   ahr_q <= wb_val;
          osr_pkg::OP_AHI:   ahi_q <= wb_val;
          osr_pkg::OP_G1R:   begin lr_q <= wb_val; br_q <= FxOne; end
          osr_pkg::OP_G1I:   begin li_q <= wb_val; bim_q <= 64'sd0; end
          osr_pkg::OP_KEEP1: t_q    <= wb_val;
          osr_pkg::OP_KEEP2: keep_q <= wb_val;
          osr_pkg::OP_CPL1:  t_q    <= wb_val;
          osr_pkg::OP_CPL2:  cpl_q  <= wb_val;
          osr_pkg::OP_GR0,
          osr_pkg::OP_GR1,
          osr_pkg::OP_GR2:   gr_q   <= wb_val;
          osr_pkg::OP_GI0,
          osr_pkg::OP_GI1:   t_q    <= wb_val;
          osr_pkg::OP_GI2:   begin
            br_q  <= lr_q;
            bim_q <= li_q;
            lr_q  <= gr_q;
            li_q  <= wb_val;
            k_q   <= k_q + 13'd1;
          end
          osr_pkg::OP_SQR:   sq_q <= mdu_prod;
          osr_pkg::OP_SQI:   sq_q <= sq_q + mdu_prod;
          default:           t_q  <= t_q;
        endcase
      end
      if (sqrt_done) begin
        res_q <= root[63] ? 63'h7FFF_FFFF_FFFF_FFFF : root[62:0];
        if (root[63]) sat_q <= 1'b1;
      end
    end
  end

  assign stat_o.done     = done_q;
  assign stat_o.loop_end = k_q == n_q;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

FILE: design/osr_ctrl.sv
// controller: sequences the op list for one item and the recurrence loop
// uses osr_pkg command and status types
module osr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  osr_pkg::stat_t stat_i,
  output osr_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {S_IDLE, S_WAIT, S_PUBLISH} state_e;

  state_e       state_q;
  osr_pkg::op_e op_q, op_nxt;
  logic         go_q;

  always_comb begin
    case (op_q)
      osr_pkg::OP_KZ2:   op_nxt = osr_pkg::OP_WIR;
      osr_pkg::OP_WIR:   op_nxt = osr_pkg::OP_BI;
      osr_pkg::OP_BI:    op_nxt = osr_pkg::OP_WRR;
      osr_pkg::OP_WRR:   op_nxt = osr_pkg::OP_AHR;
      osr_pkg::OP_AHR:   op_nxt = osr_pkg::OP_AHI;
      osr_pkg::OP_AHI:   op_nxt = osr_pkg::OP_G1R;
      osr_pkg::OP_G1R:   op_nxt = osr_pkg::OP_G1I;
      osr_pkg::OP_G1I:   op_nxt = osr_pkg::OP_KEEP1;
      osr_pkg::OP_KEEP1: op_nxt = osr_pkg::OP_KEEP2;
      osr_pkg::OP_KEEP2: op_nxt = osr_pkg::OP_CPL1;
      osr_pkg::OP_CPL1:  op_nxt = osr_pkg::OP_CPL2;
      osr_pkg::OP_CPL2:  op_nxt = osr_pkg::OP_GR0;
      osr_pkg::OP_GR0:   op_nxt = osr_pkg::OP_GR1;
      osr_pkg::OP_GR1:   op_nxt = osr_pkg::OP_GR2;
      osr_pkg::OP_GR2:   op_nxt = osr_pkg::OP_GI0;
      osr_pkg::OP_GI0:   op_nxt = osr_pkg::OP_GI1;
      osr_pkg::OP_GI1:   op_nxt = osr_pkg::OP_GI2;
      osr_pkg::OP_GI2:   op_nxt = stat_i.loop_end ? osr_pkg::OP_SQR : osr_pkg::OP_KEEP1;
      osr_pkg::OP_SQR:   op_nxt = osr_pkg::OP_SQI;
      osr_pkg::OP_SQI:   op_nxt = osr_pkg::OP_ROOT;
      default:           op_nxt = osr_pkg::OP_ROOT;
    endcase
  end

  assign in_stall_o    = state_q != S_IDLE;
  assign cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.go      = go_q;
  assign cmd_o.op      = op_q;
  assign cmd_o.publish = (state_q == S_PUBLISH) && stat_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= osr_pkg::OP_KZ2;
      go_q    <= 1'b0;
    end else begin
      go_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_o.load) begin
            op_q    <= osr_pkg::OP_KZ2;
            go_q    <= 1'b1;
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (stat_i.done) begin
            if (op_q == osr_pkg::OP_ROOT) begin
              state_q <= S_PUBLISH;
            end else begin
              op_q <= op_nxt;
              go_q <= 1'b1;
            end
          end
        end
        S_PUBLISH: begin
          if (cmd_o.publish) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.done |-> (state_q == S_WAIT) && !go_q)
    else $error("unit done outside of wait");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> go_q && (op_q == osr_pkg::OP_KZ2))
    else $error("accepted item did not start the op list");

  a_publish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |=> (state_q == S_IDLE))
    else $error("publish did not return to idle");

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for the ode shooting residual block
// depends on design/osr_pkg.sv and design/ode_shooting_residual_top.sv
`timescale 1ns / 100ps

// keeps the register copies, predicts each residual and compares the results in order
class residual_board;
  typedef logic signed [63:0] fx_t;
  localparam fx_t FxOne = 64'sh0000_1000_0000_0000;
  localparam fx_t FxMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx_t FxMin = 64'sh8000_0000_0000_0000;

  logic [62:0]   reynolds;
  logic [12:0]   steps;
  osr_pkg::out_t pending_q[$];
  int            mismatches;
  bit            clipped;

  function new();
    reynolds   = 63'(FxOne);
    steps      = 13'd2048;
    mismatches = 0;
  endfunction

  function void set_reg(osr_pkg::cfg_idx_t idx, logic [62:0] data);
    if (idx == osr_pkg::RegReynolds) reynolds = data;
    else if (idx == osr_pkg::RegSteps) steps = data[12:0];
  endfunction

  function logic [63:0] mag(fx_t x);
    return x < 0 ? -x : x;
  endfunction

  // round(x*y/d), ties away from zero, clipped to the signed range
  function fx_t mul_div(fx_t x, longint y, longint unsigned d);
    logic [127:0] p;
    logic [127:0] q;
    logic [63:0]  lim;
    bit           neg;
    neg = (x < 0) != (y < 0);
    p = {64'b0, mag(x)} * {64'b0, mag(y)};
    p = p + (d >> 1);
    q = p / d;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (q > {64'b0, lim}) begin
      clipped = 1;
      q = {64'b0, lim};
    end
    return neg ? -q[63:0] : q[63:0];
  endfunction

  function fx_t add_c(fx_t a, fx_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      clipped = 1;
      return s[64] ? FxMin : FxMax;
    end
    return s[63:0];
  endfunction

  function fx_t sub_c(fx_t a, fx_t b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      clipped = 1;
      return s[64] ? FxMin : FxMax;
    end
    return s[63:0];
  endfunction

  function fx_t neg_c(fx_t a);
    if (a == FxMin) begin
      clipped = 1;
      return FxMax;
    end
    return -a;
  endfunction

  function osr_pkg::out_t shoot(osr_pkg::in_t it);
    osr_pkg::out_t res;
    fx_t           rey, ar, ai, bi, ahr, ahi, g2r, g2i, g1r, g1i, keep, cpl, gr, gi;
    longint        n;
    logic [127:0]  sq;
    logic [63:0]   root, c;
    clipped = 0;
    rey = {1'b0, reynolds};
    n = steps;
    if (n < 2) n = 2;
    if (n > 4096) n = 4096;
    ar = sub_c(neg_c(mul_div(it.wavenumber, it.wavenumber, FxOne)),
               mul_div(it.omega_imag, rey, FxOne));
    bi = mul_div(it.wavenumber, rey, FxOne);
    ai = sub_c(mul_div(it.omega_real, rey, FxOne), bi);
    ahr = mul_div(ar, 1, n);
    ahi = mul_div(ai, 1, n);
    g2r = FxOne;
    g2i = 0;
    g1r = sub_c(FxOne, mul_div(ar, 1, 8 * n));
    g1i = neg_c(mul_div(ai, 1, 8 * n));
    for (longint k = 1; k < n; k++) begin
      keep = mul_div(sub_c(mul_div(FxOne, 8 * k, 1), ahr), 1, 4 * k + 4);
      cpl  = mul_div(add_c(mul_div(bi, k, n * n), ahi), 1, 4 * k + 4);
      gr = mul_div(g2r, 1 - k, k + 1);
      gr = add_c(gr, mul_div(g1r, keep, FxOne));
      gr = add_c(gr, mul_div(g1i, cpl, FxOne));
      gi = mul_div(g2i, 1 - k, k + 1);
      gi = add_c(gi, mul_div(g1i, keep, FxOne));
      gi = sub_c(gi, mul_div(cpl, g1r, FxOne));
      g2r = g1r;
      g2i = g1i;
      g1r = gr;
      g1i = gi;
    end
    sq = {64'b0, mag(g1r)} * {64'b0, mag(g1r)} + {64'b0, mag(g1i)} * {64'b0, mag(g1i)};
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      c = root | (64'd1 << b);
      if ({64'b0, c} * {64'b0, c} <= sq) root = c;
    end
    if (root[63]) begin
      root = 64'h7FFF_FFFF_FFFF_FFFF;
      clipped = 1;
    end
    res.residual  = root[62:0];
    res.saturated = clipped;
    return res;
  endfunction

  function void note_item(osr_pkg::in_t it);
    pending_q.push_back(shoot(it));
  endfunction

  function void check_result(osr_pkg::out_t got);
    osr_pkg::out_t want;
    if (pending_q.size() == 0) begin
      $error("result with nothing expected: residual %h saturated %b",
             got.residual, got.saturated);
      mismatches++;
      return;
    end
    want = pending_q.pop_front();
    if (got.residual !== want.residual) begin
      $error("residual: expected %h actual %h", want.residual, got.residual);
      mismatches++;
    end
    if (got.saturated !== want.saturated) begin
      $error("saturated: expected %b actual %b", want.saturated, got.saturated);
      mismatches++;
    end
  endfunction

  function int outstanding();
    return pending_q.size();
  endfunction
endclass

module tb_top;

  localparam logic [63:0] FxOne = 64'h0000_1000_0000_0000;
  localparam logic [63:0] FxMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] FxMin = 64'h8000_0000_0000_0000;
  localparam int IdleLimit = 12_000_000;
  localparam int HoldCycles = 30_000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  osr_pkg::in_t      in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  osr_pkg::out_t     out_data_o;
  logic              cfg_we_i;
  osr_pkg::cfg_idx_t cfg_idx_i;
  logic [62:0]       cfg_data_i;

  residual_board board = new();
  bit calm;      // no idling on either side while set
  bit hold_req;  // asks the receiver for one long hold-off
  int idle_cycles;

  ode_shooting_residual_top DUT (.*);

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // monitor: every accepted item goes to the predictor, every result to the checker
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.note_item(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  // watchdog on cycles without any accepted item or result
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stall before each result, one long hold-off on request
  initial begin
    int w;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      w = calm ? 0 : $urandom_range(16);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 0;
      end
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // offer one item after a random gap and wait for it to be taken
  task automatic send_item(logic [63:0] kz, logic [63:0] wr, logic [63:0] wi);
    int gap;
    gap = calm ? 0 : $urandom_range(16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{wavenumber: kz, omega_real: wr, omega_imag: wi};
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // register writes only once the block has drained
  task automatic write_reg(osr_pkg::cfg_idx_t idx, logic [62:0] data);
    in_valid_i <= 1'b0;
    // let the monitor note the last accepted item first
    @(posedge clk_i);
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(idx, data);
  endtask

  // mostly moderate magnitudes, some with every bit random
  function automatic logic [63:0] rand_fx();
    logic signed [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(4) == 0) return v;
    return v >>> $urandom_range(14, 24);
  endfunction

  task automatic random_items(int count);
    repeat (count) send_item(rand_fx(), rand_fx(), rand_fx());
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = osr_pkg::RegReynolds;
    cfg_data_i  = '0;
    calm        = 0;
    hold_req    = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // shortest grid, unit reynolds: extremes of every field
    write_reg(osr_pkg::RegSteps, 63'd2);
    write_reg(osr_pkg::RegReynolds, 63'(FxOne));
    send_item(64'd0, 64'd0, 64'd0);
    send_item(FxMax, 64'd0, 64'd0);
    send_item(FxMin, 64'd0, 64'd0);
    send_item(64'd0, FxMax, 64'd0);
    send_item(64'd0, FxMin, 64'd0);
    send_item(64'd0, 64'd0, FxMax);
    send_item(64'd0, 64'd0, FxMin);
    send_item(FxMax, FxMax, FxMax);
    send_item(FxMin, FxMin, FxMin);
    send_item('1, '1, '1);
    send_item(64'd1, 64'd1, 64'd1);
    send_item(FxOne, FxOne >> 1, -(FxOne >> 2));
    send_item(-(FxOne * 3), FxOne * 2, FxOne);

    // short grid, random items first with no idling, then with random gaps
    write_reg(osr_pkg::RegSteps, 63'd3);
    calm = 1;
    random_items(12);
    calm = 0;
    random_items(12);

    // step count below range clamps to two; zero reynolds; long receiver hold-off
    write_reg(osr_pkg::RegSteps, 63'd0);
    write_reg(osr_pkg::RegReynolds, 63'd0);
    hold_req = 1;
    random_items(15);

    // high register bits beyond the step field are ignored
    write_reg(osr_pkg::RegSteps, {50'h2_AAAA_5555_F0F0, 13'd5});
    write_reg(osr_pkg::RegReynolds, 63'(FxOne * 100));
    random_items(18);

    // step count of one clamps to two; largest reynolds saturates heavily
    write_reg(osr_pkg::RegSteps, 63'd1);
    write_reg(osr_pkg::RegReynolds, 63'h7FFF_FFFF_FFFF_FFFF);
    random_items(14);

    // tiny reynolds, slightly longer grid
    write_reg(osr_pkg::RegSteps, 63'd7);
    write_reg(osr_pkg::RegReynolds, 63'd3);
    calm = 1;
    random_items(10);
    calm = 0;
    random_items(8);

    // step count above range clamps to the largest grid, a single slow item
    write_reg(osr_pkg::RegSteps, 63'h1FFF);
    write_reg(osr_pkg::RegReynolds, 63'(FxOne));
    send_item(FxOne >> 1, FxOne >> 3, -(FxOne >> 4));
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
